[sv/blprd_pkg.sv]
// ----------------------------------------------------------------------------
// blprd_pkg: shared types and constants of the long press release detector
// Time width, configuration register codes and reset values, detector state.
// ----------------------------------------------------------------------------
package blprd_pkg;

  // timestamp width used by the detector (low bits of now_ms)
  localparam int unsigned TimeBits   = 64;
  localparam int unsigned NowBits    = 64;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 1;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t RegDebounceTime = 1'd0;
  localparam cfg_idx_t RegHoldTime     = 1'd1;

  // configuration reset values
  localparam cfg_data_t DebounceTimeRst = 16'd50;
  localparam cfg_data_t HoldTimeRst     = 16'd3000;

  // input item kinds
  localparam logic KindObserve = 1'b0;
  localparam logic KindRestart = 1'b1;

  // detector state carried from item to item
  typedef struct packed {
    logic  raw_level;
    time_t raw_change_time;
    logic  stable_level;
    logic  stable_valid;
    logic  armed;
    logic  hold_active;
    time_t press_start_time;
    time_t last_seen_time;
  } det_state_t;

endpackage

[sv/blprd_if.sv]
// ----------------------------------------------------------------------------
// blprd channel interfaces
// Valid/ready channels for samples, result flags and configuration writes.
// ----------------------------------------------------------------------------

// sample channel
interface blprd_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic                             btn_down;
  logic [blprd_pkg::NowBits-1:0]    now_ms;

  modport source (output valid, kind, btn_down, now_ms, input ready);
  modport sink   (input valid, kind, btn_down, now_ms, output ready);
endinterface

// result channel
interface blprd_out_if;
  logic valid;
  logic ready;
  logic long_release;

  modport source (output valid, long_release, input ready);
  modport sink   (input valid, long_release, output ready);
endinterface

// configuration write channel
interface blprd_cfg_if;
  logic                  valid;
  logic                  ready;
  blprd_pkg::cfg_idx_t   index;
  blprd_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/button_long_press_release_detector.sv]
// ----------------------------------------------------------------------------
// button_long_press_release_detector: long press release detector
// Debounces timestamped button samples and flags releases of long presses.
// ----------------------------------------------------------------------------
//
//   port   | dir | payload                         | role
//   -------+-----+---------------------------------+---------------------------
//   in_i   | in  | kind, btn_down, now_ms          | one sample per transfer
//   out_o  | out | long_release                    | one flag per sample
//   cfg_i  | in  | index, data                     | debounce / hold time write
//
// A sample is captured in the input register, then its flag lands in the
// result register once that register is free to take it.
// One sample per cycle sustained while out_o is ready; the single state update per cycle sets it.
// A stalled result holds the result register, and the input register takes
// one more sample before the input side stalls.
// Reset clears all detector state and loads debounce 50 ms, hold 3000 ms.
//
module button_long_press_release_detector (
  input  logic          clk_i,
  input  logic          rst_ni,
  blprd_in_if.sink      in_i,
  blprd_out_if.source   out_o,
  blprd_cfg_if.sink     cfg_i
);
  import blprd_pkg::*;

  cfg_data_t  debounce_time_q;
  cfg_data_t  hold_time_q;

  logic                s1_valid_q;
  logic                s1_kind_q;
  logic                s1_pressed_q;
  logic [NowBits-1:0]  s1_now_q;

  logic        out_valid_q;
  logic        out_flag_q;

  det_state_t  state_q;
  det_state_t  state_d;
  logic        flag_d;

  logic        advance;
  logic        in_xfer;
  logic        in_ready_w;

  // configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_time_q <= DebounceTimeRst;
      hold_time_q     <= HoldTimeRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegDebounceTime: debounce_time_q <= cfg_i.data;
        RegHoldTime:     hold_time_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // handshake: input register moves on when the result register frees up
  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready_w  = !s1_valid_q || advance;
  assign in_i.ready  = in_ready_w;
  assign in_xfer     = in_i.valid && in_ready_w;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_w) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q    <= in_i.kind;
      s1_pressed_q <= in_i.btn_down;
      s1_now_q     <= in_i.now_ms;
    end
  end

  // per-sample logic
  blprd_step u_step (
    .state_i         (state_q),
    .kind_i          (s1_kind_q),
    .btn_down_i      (s1_pressed_q),
    .now_ms_i        (s1_now_q),
    .debounce_time_i (debounce_time_q),
    .hold_time_i     (hold_time_q),
    .state_o         (state_d),
    .flag_o          (flag_d)
  );

  // detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_flag_q <= flag_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.long_release = out_flag_q;

  // checks
  a_hold_needs_armed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold_active |-> state_q.armed)
    else $error("hold timing active while detector not armed");

  a_armed_needs_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.armed |-> state_q.stable_valid)
    else $error("detector armed without a stable level");

  a_state_only_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("detector state changed without a sample");

  a_flag_ends_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && flag_d) |=> !state_q.hold_active)
    else $error("hold still active after release flag");

  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |=> (s1_valid_q && $stable(s1_now_q)))
    else $error("input register lost a sample while result stalled");

endmodule

[sv/blprd_step.sv]
// ----------------------------------------------------------------------------
// blprd_step: next-state logic for one button sample
// Debounce, arming, hold timing and release flag, all combinational.
// ----------------------------------------------------------------------------
module blprd_step (
  input  blprd_pkg::det_state_t            state_i,
  input  logic                             kind_i,
  input  logic                             btn_down_i,
  input  logic [blprd_pkg::NowBits-1:0]    now_ms_i,
  input  blprd_pkg::cfg_data_t             debounce_time_i,
  input  blprd_pkg::cfg_data_t             hold_time_i,
  output blprd_pkg::det_state_t            state_o,
  output logic                             flag_o
);
  import blprd_pkg::*;

  time_t t;
  time_t since_edge;
  time_t held;
  logic  restart;
  logic  debounced;
  logic  long_enough;

  // timestamp and time differences, modulo the time width
  assign t           = now_ms_i[TimeBits-1:0];
  assign since_edge  = t - state_i.raw_change_time;
  assign held        = state_i.raw_change_time - state_i.press_start_time;
  assign restart     = (kind_i == KindRestart) || (t < state_i.last_seen_time);
  assign debounced   = since_edge >= time_t'(debounce_time_i);
  assign long_enough = held >= time_t'(hold_time_i);

  // sample update
  always_comb begin
    state_o = state_i;
    flag_o  = 1'b0;
    priority if (restart) begin
      state_o                 = '0;
      state_o.raw_level       = btn_down_i;
      state_o.raw_change_time = t;
      state_o.last_seen_time  = t;
    end else if (btn_down_i != state_i.raw_level) begin
      state_o.last_seen_time  = t;
      state_o.raw_level       = btn_down_i;
      state_o.raw_change_time = t;
    end else if (!debounced ||
                 (state_i.stable_valid && state_i.stable_level == state_i.raw_level)) begin
      state_o.last_seen_time = t;
    end else begin
      state_o.last_seen_time = t;
      state_o.stable_valid   = 1'b1;
      state_o.stable_level   = state_i.raw_level;
      priority if (state_i.raw_level) begin
        // stable press: start timing once armed
        if (state_i.armed) begin
          state_o.hold_active      = 1'b1;
          state_o.press_start_time = state_i.raw_change_time;
        end
      end else if (!state_i.armed) begin
        // first stable release arms the detector
        state_o.armed       = 1'b1;
        state_o.hold_active = 1'b0;
      end else if (state_i.hold_active) begin
        state_o.hold_active = 1'b0;
        flag_o              = long_enough;
      end else begin
        // armed release with no hold running: only the stable level and last-seen time move
      end
    end
  end

endmodule
